// ===== rtl/tvfc_pkg.sv =====
`timescale 1ns / 1ps
package tvfc_pkg;

	localparam int MUL_DIG    = 32;
	localparam int COORD_FRAC = 16;
	localparam int COEF_FRAC  = 24;
	localparam int FRAC_SHIFT = COEF_FRAC - COORD_FRAC;

	typedef struct packed {
		logic vld;
		logic sing;
		logic neg;
	} tvfc_side_t;

endpackage

// ===== rtl/tet_vertex_flux_coefficients.sv =====
// A word taken at a clock edge passes the input registers, the difference stage, the
// multipliers, the sums and the divider stages; done marks its result for one cycle.
// Throughput: one word per cycle; busy stays low. Depth is set by the restoring divider,
// which resolves one quotient bit per stage.
// Reset: arst_n clears valid, side and difference delay flops; words in flight drop.
`timescale 1ns / 1ps
module tet_vertex_flux_coefficients import tvfc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int COEF_WIDTH  = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic signed [COORD_WIDTH-1:0] nbr0_x,
	input  logic signed [COORD_WIDTH-1:0] nbr0_y,
	input  logic signed [COORD_WIDTH-1:0] nbr0_z,
	input  logic signed [COORD_WIDTH-1:0] nbr1_x,
	input  logic signed [COORD_WIDTH-1:0] nbr1_y,
	input  logic signed [COORD_WIDTH-1:0] nbr1_z,
	input  logic signed [COORD_WIDTH-1:0] nbr2_x,
	input  logic signed [COORD_WIDTH-1:0] nbr2_y,
	input  logic signed [COORD_WIDTH-1:0] nbr2_z,
	output logic                          done,
	output logic signed [COEF_WIDTH-1:0]  coef_0,
	output logic signed [COEF_WIDTH-1:0]  coef_1,
	output logic signed [COEF_WIDTH-1:0]  coef_2,
	output logic                          singular
);

	localparam int W   = COORD_WIDTH;
	localparam int QW  = COEF_WIDTH;
	localparam int RW  = W + 1;
	localparam int XW  = 2 * RW;
	localparam int CW  = XW + 1;
	localparam int SW  = CW + 2;
	localparam int DPW = RW + CW;
	localparam int DW  = DPW + 2;
	localparam int NPW = SW + CW;
	localparam int NW  = NPW + 2;
	localparam int NNW = NW + FRAC_SHIFT + 1;
	localparam int DDW = DW + 3;

	logic signed [W-1:0]   ctr_q [3];
	logic signed [W-1:0]   nb_q  [3][3];
	logic                  v_q;
	logic signed [RW-1:0]  r_s1  [3][3];
	logic [9*RW-1:0]       r_pk;
	logic [9*RW-1:0]       r_pk_d;
	logic signed [RW-1:0]  r_s7  [3][3];
	logic signed [XW-1:0]  xa    [3][3];
	logic signed [XW-1:0]  xb    [3][3];
	logic signed [CW-1:0]  c_s6  [3][3];
	logic signed [CW-1:0]  c_s7  [3][3];
	logic signed [SW-1:0]  s_s7  [3];
	logic signed [DPW-1:0] dp    [3];
	logic signed [NPW-1:0] np    [3][3];
	logic signed [DW-1:0]  det_s12;
	logic signed [NW-1:0]  num_s12 [3];
	logic [DW-1:0]         adet_s13;
	logic [NW-1:0]         mag_s13 [3];
	logic                  neg_s13 [3];
	logic                  sing_s13;
	logic [DW+1:0]         t3_s14;
	logic [NW-1:0]         mag_s14 [3];
	logic                  neg_s14 [3];
	logic                  sing_s14;
	logic [NNW-1:0]        n_s15 [3];
	logic [DDW-1:0]        d_s15;
	logic                  neg_s15 [3];
	logic                  sing_s15;
	logic                  v_s15;
	logic [QW-1:0]         cf    [3];
	tvfc_side_t            sd_o  [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else         v_q <= start && !busy;
	end

	always_ff @(posedge clk) begin
		ctr_q[0]    <= center_x;
		ctr_q[1]    <= center_y;
		ctr_q[2]    <= center_z;
		nb_q[0][0]  <= nbr0_x;
		nb_q[0][1]  <= nbr0_y;
		nb_q[0][2]  <= nbr0_z;
		nb_q[1][0]  <= nbr1_x;
		nb_q[1][1]  <= nbr1_y;
		nb_q[1][2]  <= nbr1_z;
		nb_q[2][0]  <= nbr2_x;
		nb_q[2][1]  <= nbr2_y;
		nb_q[2][2]  <= nbr2_z;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				r_s1[i][k] <= $signed({nb_q[i][k][W-1], nb_q[i][k]})
					- $signed({ctr_q[k][W-1], ctr_q[k]});
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				r_pk[(3*i+k)*RW +: RW] = r_s1[i][k];
				r_s7[i][k] = $signed(r_pk_d[(3*i+k)*RW +: RW]);
			end
	end

	tvfc_dly #(.W(9*RW), .N(6)) u_rdly (
		.clk(clk), .arst_n(arst_n), .d(r_pk), .q(r_pk_d)
	);

	tvfc_dly #(.W(1), .N(15)) u_vdly (
		.clk(clk), .arst_n(arst_n), .d(v_q), .q(v_s15)
	);

	for (genvar gi = 0; gi < 3; gi++) begin : g_cross
		for (genvar gk = 0; gk < 3; gk++) begin : g_comp
			tvfc_mul #(.AW(RW), .BW(RW)) u_ma (
				.clk(clk),
				.a(r_s1[(gi+1)%3][(gk+1)%3]),
				.b(r_s1[(gi+2)%3][(gk+2)%3]),
				.p(xa[gi][gk])
			);
			tvfc_mul #(.AW(RW), .BW(RW)) u_mb (
				.clk(clk),
				.a(r_s1[(gi+1)%3][(gk+2)%3]),
				.b(r_s1[(gi+2)%3][(gk+1)%3]),
				.p(xb[gi][gk])
			);
			tvfc_mul #(.AW(SW), .BW(CW)) u_mn (
				.clk(clk),
				.a(s_s7[gk]),
				.b(c_s7[gi][gk]),
				.p(np[gi][gk])
			);
		end
		tvfc_mul #(.AW(RW), .BW(CW)) u_md (
			.clk(clk),
			.a(r_s7[0][gi]),
			.b(c_s7[0][gi]),
			.p(dp[gi])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				c_s6[i][k] <= CW'(xa[i][k]) - CW'(xb[i][k]);
				c_s7[i][k] <= c_s6[i][k];
			end
		for (int k = 0; k < 3; k++)
			s_s7[k] <= SW'(c_s6[0][k]) + SW'(c_s6[1][k]) + SW'(c_s6[2][k]);
		det_s12 <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
		for (int j = 0; j < 3; j++)
			num_s12[j] <= NW'(np[j][0]) + NW'(np[j][1]) + NW'(np[j][2]);
		sing_s13 <= det_s12 == '0;
		adet_s13 <= det_s12[DW-1] ? DW'(-det_s12) : DW'(det_s12);
		for (int j = 0; j < 3; j++) begin
			mag_s13[j] <= num_s12[j][NW-1] ? NW'(-num_s12[j]) : NW'(num_s12[j]);
			neg_s13[j] <= num_s12[j][NW-1];
		end
		t3_s14   <= ((DW+2)'(adet_s13) << 1) + (DW+2)'(adet_s13);
		sing_s14 <= sing_s13;
		for (int j = 0; j < 3; j++) begin
			mag_s14[j] <= mag_s13[j];
			neg_s14[j] <= neg_s13[j];
		end
		for (int j = 0; j < 3; j++) begin
			n_s15[j]   <= (NNW'(mag_s14[j]) << FRAC_SHIFT) + NNW'(t3_s14);
			neg_s15[j] <= neg_s14[j];
		end
		d_s15    <= DDW'(t3_s14) << 1;
		sing_s15 <= sing_s14;
	end

	for (genvar gj = 0; gj < 3; gj++) begin : g_div
		tvfc_side_t sd_i;

		assign sd_i = '{vld: v_s15, sing: sing_s15, neg: neg_s15[gj]};

		tvfc_div #(.NNW(NNW), .DDW(DDW), .QW(QW)) u_div (
			.clk(clk),
			.arst_n(arst_n),
			.num(n_s15[gj]),
			.den(d_s15),
			.side_i(sd_i),
			.coef(cf[gj]),
			.side_o(sd_o[gj])
		);
	end

	assign done     = sd_o[0].vld;
	assign singular = sd_o[0].sing;
	assign coef_0   = $signed(cf[0]);
	assign coef_1   = $signed(cf[1]);
	assign coef_2   = $signed(cf[2]);

endmodule

// ===== rtl/tvfc_dly.sv =====
`timescale 1ns / 1ps
module tvfc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) tap_q[i] <= '0;
		end else begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

// ===== rtl/tvfc_mul.sv =====
`timescale 1ns / 1ps
module tvfc_mul import tvfc_pkg::*; #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int AD  = (AW + MUL_DIG - 1) / MUL_DIG;
	localparam int BD  = (BW + MUL_DIG - 1) / MUL_DIG;
	localparam int APW = AD * MUL_DIG;
	localparam int BPW = BD * MUL_DIG;
	localparam int PW  = AW + BW;
	localparam int ACC = APW + BPW;

	logic [AW-1:0]          au;
	logic [BW-1:0]          bu;
	logic [APW-1:0]         ma_s1;
	logic [BPW-1:0]         mb_s1;
	logic                   sg_s1;
	logic [2*MUL_DIG-1:0]   pp_s2 [AD][BD];
	logic                   sg_s2;
	logic [ACC-1:0]         acc;
	logic [PW-1:0]          mag_s3;
	logic                   sg_s3;

	assign au = a[AW-1] ? AW'(-a) : AW'(a);
	assign bu = b[BW-1] ? BW'(-b) : BW'(b);

	always_comb begin
		acc = '0;
		for (int i = 0; i < AD; i++)
			for (int j = 0; j < BD; j++)
				acc = acc + (ACC'(pp_s2[i][j]) << (MUL_DIG * (i + j)));
	end

	always_ff @(posedge clk) begin
		ma_s1 <= APW'(au);
		mb_s1 <= BPW'(bu);
		sg_s1 <= a[AW-1] ^ b[BW-1];
		for (int i = 0; i < AD; i++)
			for (int j = 0; j < BD; j++)
				pp_s2[i][j] <= ma_s1[i*MUL_DIG +: MUL_DIG] * mb_s1[j*MUL_DIG +: MUL_DIG];
		sg_s2  <= sg_s1;
		mag_s3 <= acc[PW-1:0];
		sg_s3  <= sg_s2;
		p      <= sg_s3 ? -$signed(mag_s3) : $signed(mag_s3);
	end

endmodule

// ===== rtl/tvfc_div.sv =====
`timescale 1ns / 1ps
module tvfc_div import tvfc_pkg::*; #(
	parameter int NNW = 150,
	parameter int DDW = 105,
	parameter int QW  = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [NNW-1:0] num,
	input  logic [DDW-1:0] den,
	input  tvfc_side_t     side_i,
	output logic [QW-1:0]  coef,
	output tvfc_side_t     side_o
);

	localparam int CMW = (NNW > DDW + QW) ? NNW : DDW + QW;

	logic [CMW-1:0]  rem_st [QW];
	logic [DDW-1:0]  d_st   [QW];
	logic [QW-1:0]   q_st   [QW+1];
	logic            ov_st  [QW+1];
	tvfc_side_t      sd_st  [QW+1];
	logic [QW-1:0]   qf;
	logic            big_neg;
	logic            big_pos;

	always_ff @(posedge clk) begin
		rem_st[0] <= CMW'(num);
		d_st[0]   <= den;
		q_st[0]   <= '0;
		ov_st[0]  <= CMW'(num) >= (CMW'(den) << QW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) sd_st[i] <= '0;
			side_o <= '0;
		end else begin
			sd_st[0] <= side_i;
			for (int i = 1; i <= QW; i++) sd_st[i] <= sd_st[i-1];
			side_o <= sd_st[QW];
		end
	end

	for (genvar gk = 1; gk <= QW; gk++) begin : g_bit
		localparam int BI = QW - gk;
		logic [CMW-1:0] dsh;
		logic           ge;

		assign dsh = CMW'(d_st[gk-1]) << BI;
		assign ge  = rem_st[gk-1] >= dsh;

		always_ff @(posedge clk) begin
			q_st[gk]  <= ge ? (q_st[gk-1] | (QW'(1) << BI)) : q_st[gk-1];
			ov_st[gk] <= ov_st[gk-1];
		end

		if (gk < QW) begin : g_rem
			always_ff @(posedge clk) begin
				rem_st[gk] <= ge ? (rem_st[gk-1] - dsh) : rem_st[gk-1];
				d_st[gk]   <= d_st[gk-1];
			end
		end
	end

	assign qf      = q_st[QW];
	assign big_neg = ov_st[QW] || (qf[QW-1] && (|qf[QW-2:0]));
	assign big_pos = ov_st[QW] || qf[QW-1];

	always_ff @(posedge clk) begin
		priority if (sd_st[QW].sing)
			coef <= '0;
		else if (sd_st[QW].neg)
			coef <= big_neg ? {1'b1, {(QW-1){1'b0}}} : QW'(-qf);
		else
			coef <= big_pos ? {1'b0, {(QW-1){1'b1}}} : qf;
	end

endmodule

// ===== rtl/tvfc_chk.sv =====
`timescale 1ns / 1ps
module tvfc_chk #(
	parameter int CW  = 48,
	parameter int LAT = 66
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic          singular,
	input logic [CW-1:0] coef_0,
	input logic [CW-1:0] coef_1,
	input logic [CW-1:0] coef_2
);

	localparam int UW = $clog2(LAT + 1);

	logic [UW-1:0] up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 up_q <= '0;
		else if (up_q != UW'(LAT))   up_q <= up_q + 1'b1;
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(up_q == UW'(LAT)) |-> (done == $past(start, LAT)))
		else $error("result word out of step with its start");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && singular) |-> (coef_0 == '0 && coef_1 == '0 && coef_2 == '0))
		else $error("singular word with nonzero coefficients");

endmodule

bind tet_vertex_flux_coefficients tvfc_chk #(
	.CW(COEF_WIDTH),
	.LAT(COEF_WIDTH + 18)
) u_tvfc_chk (.*);
